// ----- sv/sss_pkg.sv -----
// shared types and constants for the screw station sequencer
package sss_pkg;

    // one scan of switches and sensors
    typedef struct packed {
        logic manual_mode;
        logic stop_key;
        logic start_key;
        logic reset_key;
        logic lift_key;
        logic clamp_key;
        logic feed_key;
        logic upper_limit;
        logic lower_limit;
        logic slip_sensor;
        logic tube_sensor;
        logic full_sensor;
    } scan_word_t;

    // one result word
    typedef struct packed {
        logic       lift_valve;
        logic       clamp_valve;
        logic       feed_valve;
        logic       driver_run;
        logic       home_signal;
        logic       finish_signal;
        logic [2:0] error_relays;
        logic [2:0] sequence_step;
        logic       homing_wait;
    } result_word_t;

    localparam int CfgIndexWidth = 3;
    localparam int CfgDataWidth  = 16;

    localparam logic [CfgIndexWidth-1:0] REG_FULL_LIMIT     = 3'd0;
    localparam logic [CfgIndexWidth-1:0] REG_VALVE_TIMEOUT  = 3'd1;
    localparam logic [CfgIndexWidth-1:0] REG_CLAMP_DWELL    = 3'd2;
    localparam logic [CfgIndexWidth-1:0] REG_SLIP_TIMEOUT   = 3'd3;
    localparam logic [CfgIndexWidth-1:0] REG_LACK_ALLOWANCE = 3'd4;
    localparam logic [CfgIndexWidth-1:0] REG_FEED_PULSE     = 3'd5;

    localparam logic [15:0] FULL_LIMIT_RST     = 16'd10000;
    localparam logic [15:0] VALVE_TIMEOUT_RST  = 16'd3000;
    localparam logic [15:0] CLAMP_DWELL_RST    = 16'd300;
    localparam logic [15:0] SLIP_TIMEOUT_RST   = 16'd2000;
    localparam logic [7:0]  LACK_ALLOWANCE_RST = 8'd1;
    localparam logic [15:0] FEED_PULSE_RST     = 16'd250;

    typedef struct packed {
        logic [15:0] full_limit;
        logic [15:0] valve_timeout;
        logic [15:0] clamp_dwell;
        logic [15:0] slip_timeout;
        logic [7:0]  lack_allowance;
        logic [15:0] feed_pulse;
    } cfg_t;

    // error codes shown on the relays
    localparam logic [2:0] ERR_NONE = 3'd0;
    localparam logic [2:0] ERR_SLIP = 3'd1;
    localparam logic [2:0] ERR_LACK = 3'd4;
    localparam logic [2:0] ERR_FULL = 3'd5;
    localparam logic [2:0] ERR_UP   = 3'd6;
    localparam logic [2:0] ERR_DOWN = 3'd7;

    // automatic sequence steps
    localparam logic [2:0] STEP_INIT      = 3'd0;
    localparam logic [2:0] STEP_WAIT      = 3'd1;
    localparam logic [2:0] STEP_DOWN      = 3'd2;
    localparam logic [2:0] STEP_CLAMP     = 3'd3;
    localparam logic [2:0] STEP_SLIP      = 3'd4;
    localparam logic [2:0] STEP_PASS      = 3'd5;
    localparam logic [2:0] STEP_UP        = 3'd6;
    localparam logic [2:0] STEP_CLAMP_OFF = 3'd7;

    localparam logic [15:0] CNT_MAX  = 16'hFFFF;
    localparam logic [7:0]  LACK_MAX = 8'hFF;

    // sequencer state carried from scan to scan
    typedef struct packed {
        logic [2:0]  step;
        logic        v_lift;
        logic        v_clamp;
        logic        v_feed;
        logic        v_drv;
        logic        entry_auto;
        logic        entry_man;
        logic        rel_lift;
        logic        rel_clamp;
        logic        rel_feed;
        logic        err_slip;
        logic        err_up;
        logic        err_down;
        logic        err_full;
        logic        err_lack;
        logic [2:0]  sticky;
        logic        scr_tube;
        logic        scr_clip;
        logic        scr_pend;
        logic        scr_arm;
        logic        finish_flag;
        logic [7:0]  lack_count;
        logic [15:0] cnt_full;
        logic [15:0] cnt_up;
        logic [15:0] cnt_down;
        logic [15:0] cnt_step;
        logic [15:0] cnt_feed;
        logic        homing;
        logic        home_out;
        logic        finish_out;
    } st_t;

    // state after reset: all keys count as released
    localparam st_t ST_RST = '{rel_lift: 1'b1, rel_clamp: 1'b1, rel_feed: 1'b1, default: '0};

endpackage

// ----- sv/sss_cfg.sv -----
// configuration registers of the screw station sequencer
module sss_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [sss_pkg::CfgIndexWidth-1:0] cfg_index,
    input  logic [sss_pkg::CfgDataWidth-1:0]  cfg_data,
    output sss_pkg::cfg_t                     cfg
);

    sss_pkg::cfg_t cfg_reg;
    sss_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                sss_pkg::REG_FULL_LIMIT:     cfg_next.full_limit     = cfg_data;
                sss_pkg::REG_VALVE_TIMEOUT:  cfg_next.valve_timeout  = cfg_data;
                sss_pkg::REG_CLAMP_DWELL:    cfg_next.clamp_dwell    = cfg_data;
                sss_pkg::REG_SLIP_TIMEOUT:   cfg_next.slip_timeout   = cfg_data;
                sss_pkg::REG_LACK_ALLOWANCE: cfg_next.lack_allowance = cfg_data[7:0];
                sss_pkg::REG_FEED_PULSE:     cfg_next.feed_pulse     = cfg_data;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.full_limit     <= sss_pkg::FULL_LIMIT_RST;
            cfg_reg.valve_timeout  <= sss_pkg::VALVE_TIMEOUT_RST;
            cfg_reg.clamp_dwell    <= sss_pkg::CLAMP_DWELL_RST;
            cfg_reg.slip_timeout   <= sss_pkg::SLIP_TIMEOUT_RST;
            cfg_reg.lack_allowance <= sss_pkg::LACK_ALLOWANCE_RST;
            cfg_reg.feed_pulse     <= sss_pkg::FEED_PULSE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- sv/sss_core.sv -----
// per-scan update logic: manual keys, auto sequence, timeouts and errors
module sss_core (
    input  sss_pkg::st_t         st,
    input  sss_pkg::cfg_t        cfg,
    input  sss_pkg::scan_word_t  scan,
    output sss_pkg::st_t         st_upd,
    output sss_pkg::result_word_t res
);

    sss_pkg::st_t s;
    logic         done;
    logic [2:0]   status;
    logic         home;
    logic         ok;

    function automatic logic [2:0] err_code(input sss_pkg::st_t x);
        logic [2:0] c;
        begin
            if (x.err_slip)      c = sss_pkg::ERR_SLIP;
            else if (x.err_lack) c = sss_pkg::ERR_LACK;
            else if (x.err_full) c = sss_pkg::ERR_FULL;
            else if (x.err_up)   c = sss_pkg::ERR_UP;
            else if (x.err_down) c = sss_pkg::ERR_DOWN;
            else                 c = sss_pkg::ERR_NONE;
            return c;
        end
    endfunction

    function automatic sss_pkg::st_t finish_home(input sss_pkg::st_t x);
        sss_pkg::st_t y;
        begin
            y             = x;
            y.v_feed      = 1'b0;
            y.v_clamp     = 1'b0;
            y.finish_flag = 1'b1;
            y.homing      = 1'b0;
            return y;
        end
    endfunction

    // clears lift and driver; waits for the upper limit if it is not made yet
    function automatic sss_pkg::st_t machine_home(input sss_pkg::st_t x, input logic up);
        sss_pkg::st_t y;
        begin
            y        = x;
            y.v_drv  = 1'b0;
            y.v_lift = 1'b0;
            y.step   = sss_pkg::STEP_INIT;
            if (up)
                y.homing = 1'b1;
            else
                y = finish_home(y);
            return y;
        end
    endfunction

    function automatic sss_pkg::st_t move_screw(input sss_pkg::st_t x);
        sss_pkg::st_t y;
        begin
            y          = x;
            y.scr_clip = x.scr_tube;
            y.scr_tube = 1'b0;
            return y;
        end
    endfunction

    always_comb
    begin
        s      = st;
        done   = 1'b0;
        status = err_code(st);
        home   = 1'b0;
        ok     = 1'b0;

        if (st.homing)
        begin
            if (!scan.upper_limit)
                s = finish_home(s);
            done = 1'b1;
        end
        else if (st.cnt_feed != '0)
        begin
            // feed pulse running: inputs ignored
            s.cnt_feed = st.cnt_feed - 16'd1;
            if (s.cnt_feed == '0)
                s.v_feed = 1'b0;
            done = 1'b1;
        end

        if (!done)
        begin
            if (status != sss_pkg::ERR_NONE)
                s.sticky = s.sticky | status;
            else
                s.sticky = '0;

            if (!scan.tube_sensor)
                s.scr_tube = 1'b1;

            if (scan.full_sensor)
            begin
                if (s.cnt_full != sss_pkg::CNT_MAX)
                    s.cnt_full = s.cnt_full + 16'd1;
                if (s.cnt_full > cfg.full_limit)
                    s.err_full = 1'b1;
            end
            else
            begin
                s.cnt_full = '0;
                s.err_full = 1'b0;
            end

            s.finish_out = s.finish_flag;

            if (scan.stop_key)
            begin
                s.err_slip = 1'b0;
                s.err_up   = 1'b0;
                s.err_down = 1'b0;
                s.err_lack = 1'b0;
                s.scr_clip = 1'b1;
            end

            home       = !scan.upper_limit && !(s.v_clamp || s.v_feed || s.v_drv);
            s.home_out = home;

            if (scan.manual_mode)
            begin
                s.step       = sss_pkg::STEP_INIT;
                s.entry_auto = 1'b0;
                if (!s.entry_man)
                begin
                    s.entry_man = 1'b1;
                    s           = machine_home(s, scan.upper_limit);
                    done        = scan.upper_limit;
                end
                if (!done)
                begin
                    // keys toggle on press, re-arm on release
                    if (s.rel_lift && !scan.lift_key)
                    begin
                        s.rel_lift = 1'b0;
                        s.v_lift   = !s.v_lift;
                        s.v_drv    = !s.v_drv;
                    end
                    if (scan.lift_key)
                        s.rel_lift = 1'b1;
                    if (s.rel_clamp && !scan.clamp_key)
                    begin
                        s.rel_clamp = 1'b0;
                        s.v_clamp   = !s.v_clamp;
                    end
                    if (scan.clamp_key)
                        s.rel_clamp = 1'b1;
                    if (scan.reset_key && s.rel_feed && !scan.feed_key)
                    begin
                        s.rel_feed = 1'b0;
                        s          = move_screw(s);
                        if (cfg.feed_pulse != '0)
                        begin
                            s.v_feed   = 1'b1;
                            s.cnt_feed = cfg.feed_pulse;
                            done       = 1'b1;
                        end
                        else
                        begin
                            s.v_feed = 1'b0;
                        end
                    end
                    if (!done && scan.feed_key)
                        s.rel_feed = 1'b1;
                end
            end
            else
            begin
                s.entry_man = 1'b0;
                if ((status != sss_pkg::ERR_NONE && status != sss_pkg::ERR_FULL)
                    || scan.stop_key)
                begin
                    s    = machine_home(s, scan.upper_limit);
                    done = scan.upper_limit;
                end
                if (!done)
                begin
                    if (!scan.lower_limit)
                        s.v_feed = 1'b1;
                    if (!scan.upper_limit)
                        s.v_feed = 1'b0;
                    if (!s.entry_auto)
                    begin
                        s.entry_auto = 1'b1;
                        s            = machine_home(s, scan.upper_limit);
                        done         = scan.upper_limit;
                    end
                end
                if (!done)
                begin
                    // limit switch lag timeouts
                    if (!s.v_lift && scan.upper_limit)
                    begin
                        if (s.cnt_up != sss_pkg::CNT_MAX)
                            s.cnt_up = s.cnt_up + 16'd1;
                        if (s.cnt_up > cfg.valve_timeout)
                            s.err_up = 1'b1;
                    end
                    else
                    begin
                        s.cnt_up = '0;
                    end
                    if (s.v_lift && scan.lower_limit)
                    begin
                        if (s.cnt_down != sss_pkg::CNT_MAX)
                            s.cnt_down = s.cnt_down + 16'd1;
                        if (s.cnt_down > cfg.valve_timeout)
                            s.err_down = 1'b1;
                    end
                    else
                    begin
                        s.cnt_down = '0;
                    end

                    // missing screw counting
                    if (!s.scr_clip && s.scr_arm)
                    begin
                        s.scr_arm = 1'b0;
                        if (s.lack_count != sss_pkg::LACK_MAX)
                            s.lack_count = s.lack_count + 8'd1;
                        if (s.lack_count > cfg.lack_allowance)
                            s.err_lack = 1'b1;
                    end
                    if (s.scr_clip)
                        s.scr_arm = 1'b1;

                    ok = !scan.stop_key
                         && (status == sss_pkg::ERR_NONE || status == sss_pkg::ERR_FULL);
                    if (ok)
                    begin
                        if (s.step == sss_pkg::STEP_INIT)
                        begin
                            s.cnt_up   = '0;
                            s.cnt_down = '0;
                            s.cnt_step = '0;
                            s.step     = sss_pkg::STEP_WAIT;
                            s.scr_pend = 1'b0;
                        end
                        if (s.step == sss_pkg::STEP_WAIT)
                        begin
                            if (s.scr_pend)
                            begin
                                s          = move_screw(s);
                                s.scr_pend = 1'b0;
                            end
                            if (!scan.start_key && scan.reset_key && !scan.upper_limit && home)
                                s.step = sss_pkg::STEP_DOWN;
                        end
                        if (s.step == sss_pkg::STEP_DOWN)
                        begin
                            s.finish_flag = 1'b0;
                            s.v_lift      = 1'b1;
                            if (!scan.lower_limit)
                                s.step = sss_pkg::STEP_CLAMP;
                        end
                        if (s.step == sss_pkg::STEP_CLAMP)
                        begin
                            s.v_drv    = 1'b1;
                            s.v_clamp  = 1'b1;
                            s.scr_pend = 1'b1;
                            if (s.cnt_step < cfg.clamp_dwell)
                            begin
                                s.cnt_step = s.cnt_step + 16'd1;
                            end
                            else
                            begin
                                s.step     = sss_pkg::STEP_SLIP;
                                s.cnt_step = '0;
                            end
                        end
                        if (s.step == sss_pkg::STEP_SLIP)
                        begin
                            if (scan.slip_sensor)
                            begin
                                s.step     = sss_pkg::STEP_PASS;
                                s.cnt_step = '0;
                            end
                            else
                            begin
                                if (s.cnt_step != sss_pkg::CNT_MAX)
                                    s.cnt_step = s.cnt_step + 16'd1;
                                if (s.cnt_step >= cfg.slip_timeout)
                                begin
                                    s.err_slip = 1'b1;
                                    s.cnt_step = '0;
                                end
                            end
                        end
                        if (s.step == sss_pkg::STEP_PASS)
                            s.step = sss_pkg::STEP_UP;
                        if (s.step == sss_pkg::STEP_UP)
                        begin
                            s.v_drv  = 1'b0;
                            s.v_lift = 1'b0;
                            if (!scan.upper_limit)
                            begin
                                s.step        = sss_pkg::STEP_CLAMP_OFF;
                                s.finish_flag = 1'b1;
                            end
                        end
                        if (s.step == sss_pkg::STEP_CLAMP_OFF)
                        begin
                            s.v_clamp = 1'b0;
                            if (!scan.reset_key)
                                s.step = sss_pkg::STEP_WAIT;
                        end
                    end
                end
            end
        end
    end

    assign st_upd = s;

    always_comb
    begin
        res.lift_valve    = s.v_lift;
        res.clamp_valve   = s.v_clamp;
        res.feed_valve    = s.v_feed;
        res.driver_run    = s.v_drv;
        res.home_signal   = s.home_out;
        res.finish_signal = s.finish_out;
        res.error_relays  = s.sticky;
        res.sequence_step = s.step;
        res.homing_wait   = s.homing;
    end

endmodule

// ----- sv/screw_station_sequencer_unit.sv -----
// top level of the screw station sequencer: input register, state, result register
// One scan word of the station's switches and sensors goes in per clock while the
// input is not stalled, and one result word comes out for each: the word waits in
// the input register until the result register is free or being emptied, then
// moves into the result register. A new scan word can be taken every cycle: the
// state update for one scan is a single pass of compare-and-count logic between
// the input register and the state and result registers, so the sustained rate
// is one word per cycle as long as the result side does not stall. While a
// result waits, one more scan word is still taken into the input register. All
// millisecond delays are counted in scans and set through the six configuration
// registers; write them by index only while the block is idle (not enforced).
module screw_station_sequencer_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              scan_valid,
    output logic                              scan_stall,
    input  sss_pkg::scan_word_t               scan,
    output logic                              result_valid,
    input  logic                              result_stall,
    output sss_pkg::result_word_t             result,
    input  logic                              cfg_write,
    input  logic [sss_pkg::CfgIndexWidth-1:0] cfg_index,
    input  logic [sss_pkg::CfgDataWidth-1:0]  cfg_data
);

    sss_pkg::cfg_t         cfg;
    sss_pkg::scan_word_t   scan_reg;
    logic                  scan_v_reg;
    logic                  scan_v_next;
    sss_pkg::st_t          st_reg;
    sss_pkg::st_t          st_next;
    sss_pkg::st_t          st_upd;
    sss_pkg::result_word_t res;
    sss_pkg::result_word_t result_reg;
    logic                  result_v_reg;
    logic                  result_v_next;
    logic                  advance;
    logic                  take;

    sss_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sss_core u_core (
        .st     (st_reg),
        .cfg    (cfg),
        .scan   (scan_reg),
        .st_upd (st_upd),
        .res    (res)
    );

    // input word moves on when the result register is free or being emptied
    assign advance    = scan_v_reg && (!result_v_reg || !result_stall);
    assign scan_stall = scan_v_reg && !advance;
    assign take       = scan_valid && !scan_stall;

    always_comb
    begin
        scan_v_next = scan_v_reg;
        if (take)
            scan_v_next = 1'b1;
        else if (advance)
            scan_v_next = 1'b0;

        result_v_next = result_v_reg;
        if (advance)
            result_v_next = 1'b1;
        else if (!result_stall)
            result_v_next = 1'b0;

        st_next = advance ? st_upd : st_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_v_reg   <= 1'b0;
            result_v_reg <= 1'b0;
            st_reg       <= sss_pkg::ST_RST;
        end
        else
        begin
            scan_v_reg   <= scan_v_next;
            result_v_reg <= result_v_next;
            st_reg       <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            scan_reg <= scan;
        if (advance)
            result_reg <= res;
    end

    assign result_valid = result_v_reg;
    assign result       = result_reg;

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> result_v_reg)
        else $error("result register not loaded after a scan word moved on");

    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !scan_v_reg |-> !scan_stall)
        else $error("input stalled with an empty input register");

    a_feed_pulse_valve: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg.cnt_feed != '0) |-> st_reg.v_feed)
        else $error("feed pulse running with feed valve off");

    a_homing_safe: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.homing |-> (!st_reg.v_lift && !st_reg.v_drv
                           && st_reg.step == sss_pkg::STEP_INIT))
        else $error("lift or driver on while homing");

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(st_reg))
        else $error("state changed without a scan word");

endmodule

// ----- tb/sv/tb_top.sv -----
// self-checking testbench for the screw station sequencer: scoreboard, stimulus, checks
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS       = 1900;
    localparam int QUIET_TAIL  = 250;
    localparam int LIMIT_CYCLES = 12_000_000;
    localparam int MAX_PRINTS  = 100;
    localparam logic [sss_pkg::CfgIndexWidth-1:0] FIRST_SPARE_REG =
        sss_pkg::REG_FEED_PULSE + 1'b1;

    // predicts the station outputs scan by scan and holds the words still due
    class station_checker;
        logic [15:0] full_limit, valve_timeout, clamp_dwell, slip_timeout, feed_pulse;
        logic [7:0]  lack_allowance;

        bit [2:0]  step;
        bit        v_lift, v_clamp, v_feed, v_drv;
        bit        entry_auto, entry_man;
        bit        rel_lift, rel_clamp, rel_feed;
        bit        err_slip, err_up, err_down, err_full, err_lack;
        bit [2:0]  sticky;
        bit        scr_tube, scr_clip, scr_pend, scr_arm;
        bit        finish_flag;
        bit [7:0]  lack_count;
        bit [15:0] cnt_full, cnt_up, cnt_down, cnt_step, cnt_feed;
        bit        homing, home_out, finish_out;

        sss_pkg::result_word_t expected_outputs[$];
        int errors, checked, done_cycles, fault_events;

        function new();
            full_limit     = sss_pkg::FULL_LIMIT_RST;
            valve_timeout  = sss_pkg::VALVE_TIMEOUT_RST;
            clamp_dwell    = sss_pkg::CLAMP_DWELL_RST;
            slip_timeout   = sss_pkg::SLIP_TIMEOUT_RST;
            lack_allowance = sss_pkg::LACK_ALLOWANCE_RST;
            feed_pulse     = sss_pkg::FEED_PULSE_RST;
            step = sss_pkg::STEP_INIT;
            rel_lift  = 1'b1;
            rel_clamp = 1'b1;
            rel_feed  = 1'b1;
        endfunction

        function void write_reg(logic [sss_pkg::CfgIndexWidth-1:0] idx, logic [15:0] data);
            case (idx)
                sss_pkg::REG_FULL_LIMIT:     full_limit     = data;
                sss_pkg::REG_VALVE_TIMEOUT:  valve_timeout  = data;
                sss_pkg::REG_CLAMP_DWELL:    clamp_dwell    = data;
                sss_pkg::REG_SLIP_TIMEOUT:   slip_timeout   = data;
                sss_pkg::REG_LACK_ALLOWANCE: lack_allowance = data[7:0];
                sss_pkg::REG_FEED_PULSE:     feed_pulse     = data;
                default: ;
            endcase
        endfunction

        function logic [2:0] fault_code();
            if (err_slip) return sss_pkg::ERR_SLIP;
            if (err_lack) return sss_pkg::ERR_LACK;
            if (err_full) return sss_pkg::ERR_FULL;
            if (err_up)   return sss_pkg::ERR_UP;
            if (err_down) return sss_pkg::ERR_DOWN;
            return sss_pkg::ERR_NONE;
        endfunction

        function void shift_screw();
            scr_clip = scr_tube;
            scr_tube = 1'b0;
        endfunction

        function void end_homing();
            v_feed      = 1'b0;
            v_clamp     = 1'b0;
            finish_flag = 1'b1;
            homing      = 1'b0;
        endfunction

        // true when the head is still low and homing has to wait
        function bit go_home(bit up);
            v_drv  = 1'b0;
            v_lift = 1'b0;
            step   = sss_pkg::STEP_INIT;
            if (up)
            begin
                homing = 1'b1;
                return 1'b1;
            end
            end_homing();
            return 1'b0;
        endfunction

        function void advance_scan(sss_pkg::scan_word_t s);
            logic [2:0] status;
            bit         at_home, up, down, blocked;
            up   = s.upper_limit;
            down = s.lower_limit;
            if (homing)
            begin
                if (!up) end_homing();
                return;
            end
            // feed pulse running: inputs are not looked at
            if (cnt_feed != 0)
            begin
                cnt_feed--;
                if (cnt_feed == 0) v_feed = 1'b0;
                return;
            end

            status = fault_code();
            if (status != sss_pkg::ERR_NONE) sticky |= status;
            else sticky = 3'b000;

            if (!s.tube_sensor) scr_tube = 1'b1;

            if (s.full_sensor)
            begin
                if (cnt_full != sss_pkg::CNT_MAX) cnt_full++;
                if (cnt_full > full_limit) err_full = 1'b1;
            end
            else
            begin
                cnt_full = '0;
                err_full = 1'b0;
            end

            finish_out = finish_flag;

            if (s.stop_key)
            begin
                err_slip = 1'b0;
                err_up   = 1'b0;
                err_down = 1'b0;
                err_lack = 1'b0;
                scr_clip = 1'b1;
            end

            at_home  = !up && !v_clamp && !v_feed && !v_drv;
            home_out = at_home;

            if (s.manual_mode)
            begin
                step       = sss_pkg::STEP_INIT;
                entry_auto = 1'b0;
                if (!entry_man)
                begin
                    entry_man = 1'b1;
                    if (go_home(up)) return;
                end
                if (rel_lift && !s.lift_key)
                begin
                    rel_lift = 1'b0;
                    v_lift   = !v_lift;
                    v_drv    = !v_drv;
                end
                if (s.lift_key) rel_lift = 1'b1;
                if (rel_clamp && !s.clamp_key)
                begin
                    rel_clamp = 1'b0;
                    v_clamp   = !v_clamp;
                end
                if (s.clamp_key) rel_clamp = 1'b1;
                if (s.reset_key && rel_feed && !s.feed_key)
                begin
                    rel_feed = 1'b0;
                    shift_screw();
                    if (feed_pulse != 0)
                    begin
                        v_feed   = 1'b1;
                        cnt_feed = feed_pulse;
                        return;
                    end
                    v_feed = 1'b0;
                end
                if (s.feed_key) rel_feed = 1'b1;
                return;
            end

            entry_man = 1'b0;
            // a full error alone does not stop the sequence
            blocked = s.stop_key
                      || (status != sss_pkg::ERR_NONE && status != sss_pkg::ERR_FULL);
            if (blocked)
            begin
                if (go_home(up)) return;
            end
            if (!down) v_feed = 1'b1;
            if (!up) v_feed = 1'b0;
            if (!entry_auto)
            begin
                entry_auto = 1'b1;
                if (go_home(up)) return;
            end

            if (!v_lift && up)
            begin
                if (cnt_up != sss_pkg::CNT_MAX) cnt_up++;
                if (cnt_up > valve_timeout) err_up = 1'b1;
            end
            else cnt_up = '0;
            if (v_lift && down)
            begin
                if (cnt_down != sss_pkg::CNT_MAX) cnt_down++;
                if (cnt_down > valve_timeout) err_down = 1'b1;
            end
            else cnt_down = '0;

            if (!scr_clip && scr_arm)
            begin
                scr_arm = 1'b0;
                if (lack_count != sss_pkg::LACK_MAX) lack_count++;
                if (lack_count > lack_allowance) err_lack = 1'b1;
            end
            if (scr_clip) scr_arm = 1'b1;

            if (blocked) return;
            if (step == sss_pkg::STEP_INIT)
            begin
                cnt_up   = '0;
                cnt_down = '0;
                cnt_step = '0;
                step     = sss_pkg::STEP_WAIT;
                scr_pend = 1'b0;
            end
            if (step == sss_pkg::STEP_WAIT)
            begin
                if (scr_pend)
                begin
                    shift_screw();
                    scr_pend = 1'b0;
                end
                if (!s.start_key && s.reset_key && !up && at_home) step = sss_pkg::STEP_DOWN;
            end
            if (step == sss_pkg::STEP_DOWN)
            begin
                finish_flag = 1'b0;
                v_lift      = 1'b1;
                if (!down) step = sss_pkg::STEP_CLAMP;
            end
            if (step == sss_pkg::STEP_CLAMP)
            begin
                v_drv    = 1'b1;
                v_clamp  = 1'b1;
                scr_pend = 1'b1;
                if (cnt_step < clamp_dwell) cnt_step++;
                else
                begin
                    step     = sss_pkg::STEP_SLIP;
                    cnt_step = '0;
                end
            end
            if (step == sss_pkg::STEP_SLIP)
            begin
                if (s.slip_sensor)
                begin
                    step     = sss_pkg::STEP_PASS;
                    cnt_step = '0;
                end
                else
                begin
                    if (cnt_step != sss_pkg::CNT_MAX) cnt_step++;
                    if (cnt_step >= slip_timeout)
                    begin
                        err_slip = 1'b1;
                        cnt_step = '0;
                    end
                end
            end
            if (step == sss_pkg::STEP_PASS) step = sss_pkg::STEP_UP;
            if (step == sss_pkg::STEP_UP)
            begin
                v_drv  = 1'b0;
                v_lift = 1'b0;
                if (!up)
                begin
                    step        = sss_pkg::STEP_CLAMP_OFF;
                    finish_flag = 1'b1;
                    done_cycles++;
                end
            end
            if (step == sss_pkg::STEP_CLAMP_OFF)
            begin
                v_clamp = 1'b0;
                if (!s.reset_key) step = sss_pkg::STEP_WAIT;
            end
        endfunction

        // returns 1 when the scan word was acted on rather than skipped
        function bit take_scan(sss_pkg::scan_word_t s);
            sss_pkg::result_word_t r;
            bit                    acted;
            logic [2:0]            code_before;
            acted       = !homing && cnt_feed == 0;
            code_before = fault_code();
            advance_scan(s);
            if (code_before == sss_pkg::ERR_NONE && fault_code() != sss_pkg::ERR_NONE)
                fault_events++;
            r.lift_valve    = v_lift;
            r.clamp_valve   = v_clamp;
            r.feed_valve    = v_feed;
            r.driver_run    = v_drv;
            r.home_signal   = home_out;
            r.finish_signal = finish_out;
            r.error_relays  = sticky;
            r.sequence_step = step;
            r.homing_wait   = homing;
            expected_outputs.push_back(r);
            return acted;
        endfunction

        task report(string msg);
            if (errors < MAX_PRINTS) $display("mismatch: %s", msg);
            errors++;
        endtask

        task compare_field(string name, logic [2:0] got, logic [2:0] want);
            if (got !== want)
                report($sformatf("result %0d: %s is %0d, expected %0d", checked, name, got, want));
        endtask

        task check_output(sss_pkg::result_word_t got);
            sss_pkg::result_word_t want;
            if (expected_outputs.size() == 0)
            begin
                report("result word with nothing expected");
                return;
            end
            want = expected_outputs.pop_front();
            checked++;
            compare_field("lift_valve", got.lift_valve, want.lift_valve);
            compare_field("clamp_valve", got.clamp_valve, want.clamp_valve);
            compare_field("feed_valve", got.feed_valve, want.feed_valve);
            compare_field("driver_run", got.driver_run, want.driver_run);
            compare_field("home_signal", got.home_signal, want.home_signal);
            compare_field("finish_signal", got.finish_signal, want.finish_signal);
            compare_field("error_relays", got.error_relays, want.error_relays);
            compare_field("sequence_step", got.sequence_step, want.sequence_step);
            compare_field("homing_wait", got.homing_wait, want.homing_wait);
        endtask
    endclass

    logic                                  clk = 1'b0;
    logic                                  rst_n = 1'b0;
    logic                                  scan_valid = 1'b0;
    logic                                  scan_stall;
    sss_pkg::scan_word_t                   scan = '0;
    logic                                  result_valid;
    logic                                  result_stall = 1'b0;
    sss_pkg::result_word_t                 result;
    logic                                  cfg_write = 1'b0;
    logic [sss_pkg::CfgIndexWidth-1:0]     cfg_index = '0;
    logic [sss_pkg::CfgDataWidth-1:0]      cfg_data = '0;

    station_checker sb;
    int  cycle_count = 0;
    int  words_sent = 0;
    int  live_words = 0;
    int  settings_used = 1;
    bit  quiet = 1'b0;

    // simple plant: head position between top (0) and bottom (travel)
    int  head_pos = 0;
    int  travel = 2;
    bit  full_run = 1'b0;
    int  seg_left = 0;
    bit  seg_manual = 1'b0;

    screw_station_sequencer_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .scan_valid   (scan_valid),
        .scan_stall   (scan_stall),
        .scan         (scan),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk) cycle_count <= cycle_count + 1;

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall) sb.check_output(result);
    end

    // result side backpressure in random bursts
    initial
    begin
        int burst;
        burst = 0;
        forever
        begin
            @(posedge clk);
            if (burst > 0)
            begin
                burst--;
                result_stall <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                burst = $urandom_range(1, 18) - 1;
                result_stall <= 1'b1;
            end
            else result_stall <= 1'b0;
        end
    end

    initial
    begin
        while (cycle_count < LIMIT_CYCLES) @(posedge clk);
        $display("timeout after %0d cycles, %0d results still due", cycle_count,
                 sb.expected_outputs.size());
        $display("tb_top: FAIL");
        $finish;
    end

    task automatic push_scan(input sss_pkg::scan_word_t w);
        bit acted;
        if (!quiet && $urandom_range(0, 9) == 0)
        begin
            scan_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        scan_valid <= 1'b1;
        scan       <= w;
        do
        begin
            @(posedge clk);
        end
        while (scan_stall);
        acted = sb.take_scan(w);
        words_sent++;
        if (acted) live_words++;
        quiet = (words_sent >= ITEMS - QUIET_TAIL);
    endtask

    function automatic sss_pkg::scan_word_t at_rest(bit manual);
        sss_pkg::scan_word_t w;
        w = '0;
        w.manual_mode = manual;
        w.start_key   = 1'b1;
        w.reset_key   = 1'b1;
        w.lift_key    = 1'b1;
        w.clamp_key   = 1'b1;
        w.feed_key    = 1'b1;
        w.lower_limit = 1'b1;
        w.tube_sensor = 1'b1;
        return w;
    endfunction

    // mostly well-formed station behavior, with some raw noise words
    function automatic sss_pkg::scan_word_t make_word();
        sss_pkg::scan_word_t w;
        logic [11:0] raw;
        logic [2:0]  code;
        if (seg_left == 0)
        begin
            seg_manual = ($urandom_range(0, 9) < 3);
            seg_left   = seg_manual ? $urandom_range(8, 40) : $urandom_range(30, 150);
        end
        seg_left--;
        if (sb.v_lift)
        begin
            if (head_pos < travel) head_pos++;
        end
        else if (head_pos > 0) head_pos--;
        if ($urandom_range(0, 39) == 0) full_run = !full_run;
        if ($urandom_range(0, 11) == 0)
        begin
            raw = 12'($urandom_range(0, 4095));
            w   = raw;
            return w;
        end
        code = sb.fault_code();
        w.manual_mode = seg_manual;
        if (code != sss_pkg::ERR_NONE && code != sss_pkg::ERR_FULL)
            w.stop_key = ($urandom_range(0, 4) == 0);
        else w.stop_key = ($urandom_range(0, 49) == 0);
        w.start_key = ($urandom_range(0, 4) >= 2);
        if (sb.step == sss_pkg::STEP_CLAMP_OFF) w.reset_key = 1'($urandom_range(0, 1));
        else w.reset_key = ($urandom_range(0, 9) != 0);
        w.lift_key    = ($urandom_range(0, 9) >= 3);
        w.clamp_key   = ($urandom_range(0, 9) >= 3);
        w.feed_key    = ($urandom_range(0, 9) >= 3);
        w.upper_limit = (head_pos != 0) ^ ($urandom_range(0, 29) == 0);
        w.lower_limit = (head_pos != travel) ^ ($urandom_range(0, 29) == 0);
        if (sb.step == sss_pkg::STEP_SLIP) w.slip_sensor = ($urandom_range(0, 3) == 0);
        else w.slip_sensor = ($urandom_range(0, 9) == 0);
        w.tube_sensor = ($urandom_range(0, 9) < 3);
        w.full_sensor = full_run ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 19) == 0);
        return w;
    endfunction

    // let a running feed pulse or a homing wait finish
    task automatic drain_busy();
        while (sb.homing || sb.cnt_feed != 0) push_scan(make_word());
    endtask

    task automatic put_reg(input logic [sss_pkg::CfgIndexWidth-1:0] idx,
                           input logic [15:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    task automatic write_settings(input logic [15:0] full, valve, dwell, slip,
                                  input logic [7:0] lack, input logic [15:0] feed);
        scan_valid <= 1'b0;
        while (sb.expected_outputs.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        put_reg(sss_pkg::REG_FULL_LIMIT, full);
        put_reg(sss_pkg::REG_VALVE_TIMEOUT, valve);
        put_reg(sss_pkg::REG_CLAMP_DWELL, dwell);
        put_reg(sss_pkg::REG_SLIP_TIMEOUT, slip);
        put_reg(sss_pkg::REG_LACK_ALLOWANCE, {8'($urandom), lack});
        put_reg(sss_pkg::REG_FEED_PULSE, feed);
        // unused index must leave everything alone
        put_reg(FIRST_SPARE_REG + 3'($urandom_range(0, 1)), 16'($urandom));
        cfg_write <= 1'b0;
        settings_used++;
    endtask

    task automatic run_phase(input logic [15:0] full, valve, dwell, slip,
                             input logic [7:0] lack, input logic [15:0] feed, input int budget);
        write_settings(full, valve, dwell, slip, lack, feed);
        travel = $urandom_range(1, 4);
        if (head_pos > travel) head_pos = travel;
        repeat (budget) push_scan(make_word());
        drain_busy();
    endtask

    task automatic run_directed();
        sss_pkg::scan_word_t w;
        w = '1;
        push_scan(w);                       // manual entry with head low: homing waits
        push_scan(w);
        push_scan(at_rest(1'b1));           // upper limit reached ends homing
        w = at_rest(1'b1);
        w.lift_key = 1'b0;
        push_scan(w);                       // lift and driver on
        push_scan(w);                       // held key does not toggle again
        push_scan(at_rest(1'b1));
        w = at_rest(1'b1);
        w.clamp_key = 1'b0;
        push_scan(w);
        push_scan(at_rest(1'b1));
        w = at_rest(1'b1);
        w.lift_key    = 1'b0;
        w.tube_sensor = 1'b0;
        push_scan(w);
        push_scan(at_rest(1'b1));
        w = at_rest(1'b0);
        w.upper_limit = 1'b1;
        push_scan(w);                       // auto entry, homing waits
        push_scan(at_rest(1'b0));
        push_scan(at_rest(1'b0));
        w = at_rest(1'b0);
        w.start_key = 1'b0;
        push_scan(w);                       // start: head goes down
        w = at_rest(1'b0);
        w.upper_limit = 1'b1;
        w.lower_limit = 1'b0;
        push_scan(w);                       // bottom reached, clamp dwell
        w.slip_sensor = 1'b1;
        w.full_sensor = 1'b1;
        push_scan(w);
        w.stop_key = 1'b1;
        push_scan(w);                       // stop sends the machine home
        w = at_rest(1'b0);
        w.full_sensor = 1'b1;
        push_scan(w);
        w = '0;
        push_scan(w);
        w = at_rest(1'b1);
        push_scan(w);
        w.feed_key    = 1'b0;
        w.tube_sensor = 1'b0;
        push_scan(w);                       // feed pulse starts
        head_pos = 0;
    endtask

    initial
    begin
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        drain_busy();
        repeat (100) push_scan(make_word());
        drain_busy();

        // register extremes, then many small settings that make timeouts reachable
        run_phase('0, '0, '0, '0, '0, '0, 150);
        run_phase(sss_pkg::CNT_MAX, sss_pkg::CNT_MAX, sss_pkg::CNT_MAX, sss_pkg::CNT_MAX,
                  sss_pkg::LACK_MAX, 16'd20, 60);
        while (words_sent < ITEMS)
            run_phase(16'($urandom_range(0, 12)), 16'($urandom_range(0, 8)),
                      16'($urandom_range(0, 5)), 16'($urandom_range(0, 8)),
                      8'($urandom_range(0, 4)), 16'($urandom_range(0, 6)), 150);

        scan_valid <= 1'b0;
        while (sb.expected_outputs.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.expected_outputs.size() != 0) sb.report("expected result words left over");

        $display("sent %0d scan words (%0d acted on) across %0d register settings",
                 words_sent, live_words, settings_used);
        $display("checked %0d result words, %0d screwing cycles finished, %0d faults raised",
                 sb.checked, sb.done_cycles, sb.fault_events);
        if (sb.errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
